// ----- hdl/sph_pkg.sv -----
// shared types and constants for the stepper positioner with homing
package sph_pkg;

	localparam int CMD_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int AMT_W      = 16;
	localparam int MM_W       = 24;
	localparam int STEP_W     = 35;
	localparam int SUM_W      = 36;

	localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HOME    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STEP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EDGE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_MS_TICK = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPM      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_PER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_PER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd5;

	localparam logic [15:0] RST_FACTOR   = 16'd256;
	localparam logic [10:0] RST_SPM      = 11'd100;
	localparam logic [15:0] RST_MAX      = 16'd4000;
	localparam logic [15:0] RST_MOVE_PER = 16'd1000;
	localparam logic [15:0] RST_HOME_PER = 16'd2000;
	localparam logic [9:0]  RST_DEBOUNCE = 10'd20;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [AMT_W-1:0] move_amount;
		logic                    switch_level;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        motor_enable;
		logic        drive_direction;
		logic        is_moving;
		logic        is_homing;
		logic        is_home;
		logic [15:0] current_position;
		logic [15:0] timer_period;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic mul1;
		logic mul2;
		logic clamp;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic is_move;
	} dp_stat_t;

endpackage

// ----- hdl/sph_ctrl.sv -----
// control state machine sequencing capture, move conversion and result transfer
module sph_ctrl import sph_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL1  = 5'b00010,
		S_MUL2  = 5'b00100,
		S_CLAMP = 5'b01000,
		S_APPLY = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire;
	logic   apply_fire;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	assign cmd.capture = in_fire;
	assign cmd.mul1    = (state_q == S_MUL1);
	assign cmd.mul2    = (state_q == S_MUL2);
	assign cmd.clamp   = (state_q == S_CLAMP);
	assign cmd.apply   = apply_fire;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = stat.is_move ? S_MUL1 : S_APPLY;
				end
			end
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_CLAMP;
			S_CLAMP: state_d = S_APPLY;
			S_APPLY: begin
				if (apply_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_apply_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not loaded into empty output slot");

endmodule

// ----- hdl/sph_dp.sv -----
// datapath: setup registers, motor state, move conversion and result register
module sph_dp import sph_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output out_item_t            out_data
);

	localparam int CW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

	// setup registers
	logic [15:0] factor_q, max_q, move_per_q, home_per_q;
	logic [10:0] spm_q;
	logic [9:0]  deb_q;

	// motor state
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [15:0]              sl_q, sl_n;
	logic                     dir_q, mov_q, hom_q, seen_q, en_q;
	logic                     dir_n, mov_n, hom_n, seen_n, en_n;
	logic [15:0]              ms_q, ms_n;

	// captured item and move pipeline
	logic [CMD_W-1:0]        cmd_q;
	logic signed [AMT_W-1:0] amt_q;
	logic                    lvl_q;
	logic [MM_W-1:0]         mm_q;
	logic [STEP_W-1:0]       steps_q;
	logic [15:0]             final_q;

	out_item_t out_q;

	logic [AMT_W-1:0]  mag;
	logic [31:0]       prod1;
	logic [STEP_W-1:0] prod2;
	logic [SUM_W-1:0]  pos_w, st_w, max_w, up_t, dn_t, tgt;
	logic [15:0]       fin;
	logic [CW-1:0]     fin_c, pos_c, span;
	logic              fin_gt;
	logic              acc, stop;

	assign stat.is_move = (in_data.command == CMD_MOVE);
	assign out_data     = out_q;

	assign mag   = amt_q[AMT_W-1] ? (~amt_q + 1'b1) : amt_q;
	assign prod1 = 32'(mag) * 32'(factor_q);
	assign prod2 = STEP_W'(mm_q) * STEP_W'(spm_q);

	// clamp target to [0, max]
	assign pos_w = SUM_W'(pos_q);
	assign st_w  = SUM_W'(steps_q);
	assign max_w = SUM_W'(max_q);
	assign up_t  = pos_w + st_w;
	assign dn_t  = (st_w >= pos_w) ? '0 : (pos_w - st_w);
	assign tgt   = amt_q[AMT_W-1] ? dn_t : up_t;
	assign fin   = (tgt > max_w) ? max_q : tgt[15:0];

	assign fin_c  = CW'(final_q);
	assign pos_c  = CW'(pos_q);
	assign fin_gt = fin_c > pos_c;
	assign span   = fin_gt ? (fin_c - pos_c) : (pos_c - fin_c);

	always_comb begin
		pos_n  = pos_q;
		sl_n   = sl_q;
		dir_n  = dir_q;
		mov_n  = mov_q;
		hom_n  = hom_q;
		seen_n = seen_q;
		en_n   = en_q;
		ms_n   = ms_q;
		acc    = 1'b1;
		stop   = 1'b0;
		case (cmd_q)
			CMD_MOVE: begin
				if (amt_q != '0) begin
					if (fin_c == pos_c) begin
						acc = 1'b0;
					end else begin
						dir_n = fin_gt;
						en_n  = 1'b1;
						sl_n  = span[15:0];
						mov_n = 1'b1;
						hom_n = 1'b0;
					end
				end
			end
			CMD_HOME: begin
				if (!seen_q) begin
					dir_n = 1'b0;
					en_n  = 1'b1;
					mov_n = 1'b1;
					hom_n = 1'b1;
				end
			end
			CMD_STOP: stop = 1'b1;
			CMD_STEP: begin
				if (!hom_q) begin
					if (sl_q != '0) begin
						sl_n = sl_q - 1'b1;
						if (dir_q) begin
							if (pos_q != '1) begin
								pos_n = pos_q + 1'b1;
							end
						end else if (pos_q != '0) begin
							pos_n = pos_q - 1'b1;
						end
					end
					if (pos_n == '0) begin
						sl_n = '0;
					end
					if (CW'(pos_n) >= CW'(max_q)) begin
						pos_n = POSITION_BITS'(max_q);
						sl_n  = '0;
					end
					if (sl_n == '0) begin
						stop = 1'b1;
					end
				end
			end
			CMD_EDGE: begin
				if (ms_q > 16'(deb_q)) begin
					seen_n = !lvl_q;
					if (!lvl_q && hom_q) begin
						stop  = 1'b1;
						pos_n = '0;
					end
				end
				ms_n = '0;
			end
			CMD_MS_TICK: begin
				if (ms_q != '1) begin
					ms_n = ms_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (stop) begin
			hom_n = 1'b0;
			sl_n  = '0;
			mov_n = 1'b0;
			en_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q   <= RST_FACTOR;
			spm_q      <= RST_SPM;
			max_q      <= RST_MAX;
			move_per_q <= RST_MOVE_PER;
			home_per_q <= RST_HOME_PER;
			deb_q      <= RST_DEBOUNCE;
			pos_q      <= '0;
			sl_q       <= '0;
			dir_q      <= 1'b0;
			mov_q      <= 1'b0;
			hom_q      <= 1'b0;
			seen_q     <= 1'b0;
			en_q       <= 1'b0;
			ms_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FACTOR:   factor_q   <= cfg_data;
					CFG_SPM:      spm_q      <= cfg_data[10:0];
					CFG_MAX:      max_q      <= cfg_data;
					CFG_MOVE_PER: move_per_q <= cfg_data;
					CFG_HOME_PER: home_per_q <= cfg_data;
					CFG_DEBOUNCE: deb_q      <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (cmd.apply) begin
				pos_q  <= pos_n;
				sl_q   <= sl_n;
				dir_q  <= dir_n;
				mov_q  <= mov_n;
				hom_q  <= hom_n;
				seen_q <= seen_n;
				en_q   <= en_n;
				ms_q   <= ms_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_data.command;
			amt_q <= in_data.move_amount;
			lvl_q <= in_data.switch_level;
		end
		if (cmd.mul1) begin
			mm_q <= prod1[31:8];
		end
		if (cmd.mul2) begin
			steps_q <= prod2;
		end
		if (cmd.clamp) begin
			final_q <= fin;
		end
		if (cmd.apply) begin
			out_q.accepted         <= acc;
			out_q.motor_enable     <= en_n;
			out_q.drive_direction  <= dir_n;
			out_q.is_moving        <= mov_n;
			out_q.is_homing        <= hom_n;
			out_q.is_home          <= seen_n;
			out_q.current_position <= 16'(pos_n);
			out_q.timer_period     <= hom_n ? home_per_q : move_per_q;
		end
	end

	a_steps_only_when_moving: assert property (@(posedge clk) disable iff (!arst_n)
		!mov_q |-> (sl_q == '0))
		else $error("steps remain while motor is stopped");

	a_homing_drives: assert property (@(posedge clk) disable iff (!arst_n)
		hom_q |-> (mov_q && en_q))
		else $error("homing without an energized, moving motor");

endmodule

// ----- hdl/stepper_positioner_with_homing.sv -----
// top level of the stepper positioner with homing
// a move result passes the MUL1, MUL2, CLAMP and APPLY states before it is valid, others go straight to APPLY
// a new item is taken only in the idle state, after the previous one has left APPLY
// the move path runs through the two chained multipliers and the range clamp stage
// a new item is taken while the previous result still waits in the output register
// reset clears position, motion state and debounce counter and loads setup defaults
module stepper_positioner_with_homing import sph_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	sph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sph_dp #(
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

// ----- tb/sph_checker.sv -----
// checker for the stepper positioner: predicts each result and compares it field by field
`timescale 1ns / 1ps
module sph_checker import sph_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   outstanding,
	output int                   failures,
	output int                   results_checked,
	output int                   zero_moves,
	output int                   homes_done
);

	logic [15:0] factor_r;
	logic [10:0] spm_r;
	logic [15:0] max_r;
	logic [15:0] move_per_r;
	logic [15:0] home_per_r;
	logic [9:0]  debounce_r;

	logic [15:0] pos_q;
	logic [15:0] steps_q;
	logic [15:0] ms_q;
	logic        dir_q;
	logic        moving_q;
	logic        homing_q;
	logic        seen_q;
	logic        enable_q;

	out_item_t   pending_q[$];

	task automatic report_mismatch(string what, longint got, longint want);
		failures++;
		if (failures <= 20)
			$display("%0t ns: %s differs, got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic void halt_motor();
		homing_q = 1'b0;
		steps_q  = '0;
		moving_q = 1'b0;
		enable_q = 1'b0;
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t r;
		logic      ok;
		longint    mag;
		longint    steps;
		longint    here;
		ok = 1'b1;
		case (it.command)
			CMD_MOVE: begin
				if (it.move_amount != 0) begin
					mag = (it.move_amount < 0) ? -longint'(it.move_amount)
					                           : longint'(it.move_amount);
					steps = ((mag * longint'(factor_r)) >>> 8) * longint'(spm_r);
					if (it.move_amount < 0)
						steps = -steps;
					here = longint'(pos_q);
					if (here + steps < 0)
						steps = -here;
					if (here + steps > longint'(max_r))
						steps = longint'(max_r) - here;
					if (steps == 0) begin
						ok = 1'b0;
						zero_moves++;
					end else begin
						dir_q    = steps > 0;
						enable_q = 1'b1;
						steps_q  = 16'((steps < 0) ? -steps : steps);
						moving_q = 1'b1;
						homing_q = 1'b0;
					end
				end
			end
			CMD_HOME: begin
				if (!seen_q) begin
					dir_q    = 1'b0;
					enable_q = 1'b1;
					moving_q = 1'b1;
					homing_q = 1'b1;
				end
			end
			CMD_STOP: halt_motor();
			CMD_STEP: begin
				if (!homing_q) begin
					if (steps_q != 0) begin
						steps_q = steps_q - 16'd1;
						if (dir_q) begin
							if (pos_q != 16'hFFFF)
								pos_q = pos_q + 16'd1;
						end else if (pos_q != 0) begin
							pos_q = pos_q - 16'd1;
						end
					end
					if (pos_q == 0)
						steps_q = '0;
					if (pos_q >= max_r) begin
						pos_q   = max_r;
						steps_q = '0;
					end
					if (steps_q == 0)
						halt_motor();
				end
			end
			CMD_EDGE: begin
				if (ms_q > debounce_r) begin
					seen_q = !it.switch_level;
					if (seen_q && homing_q) begin
						halt_motor();
						pos_q = '0;
						homes_done++;
					end
				end
				ms_q = '0;
			end
			CMD_MS_TICK: begin
				if (ms_q != 16'hFFFF)
					ms_q = ms_q + 16'd1;
			end
			default: ;
		endcase
		r.accepted         = ok;
		r.motor_enable     = enable_q;
		r.drive_direction  = dir_q;
		r.is_moving        = moving_q;
		r.is_homing        = homing_q;
		r.is_home          = seen_q;
		r.current_position = pos_q;
		r.timer_period     = homing_q ? home_per_r : move_per_r;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			factor_r   = RST_FACTOR;
			spm_r      = RST_SPM;
			max_r      = RST_MAX;
			move_per_r = RST_MOVE_PER;
			home_per_r = RST_HOME_PER;
			debounce_r = RST_DEBOUNCE;
			pos_q      = '0;
			steps_q    = '0;
			ms_q       = '0;
			dir_q      = 1'b0;
			moving_q   = 1'b0;
			homing_q   = 1'b0;
			seen_q     = 1'b0;
			enable_q   = 1'b0;
			pending_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FACTOR:   factor_r   = cfg_data;
					CFG_SPM:      spm_r      = cfg_data[10:0];
					CFG_MAX:      max_r      = cfg_data;
					CFG_MOVE_PER: move_per_r = cfg_data;
					CFG_HOME_PER: home_per_r = cfg_data;
					CFG_DEBOUNCE: debounce_r = cfg_data[9:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				results_checked++;
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected result, position", out_data.current_position, 0);
				end else begin
					want = pending_q.pop_front();
					if (out_data.accepted !== want.accepted)
						report_mismatch("accepted", out_data.accepted, want.accepted);
					if (out_data.motor_enable !== want.motor_enable)
						report_mismatch("motor_enable", out_data.motor_enable, want.motor_enable);
					if (out_data.drive_direction !== want.drive_direction)
						report_mismatch("drive_direction", out_data.drive_direction,
						                want.drive_direction);
					if (out_data.is_moving !== want.is_moving)
						report_mismatch("is_moving", out_data.is_moving, want.is_moving);
					if (out_data.is_homing !== want.is_homing)
						report_mismatch("is_homing", out_data.is_homing, want.is_homing);
					if (out_data.is_home !== want.is_home)
						report_mismatch("is_home", out_data.is_home, want.is_home);
					if (out_data.current_position !== want.current_position)
						report_mismatch("current_position", out_data.current_position,
						                want.current_position);
					if (out_data.timer_period !== want.timer_period)
						report_mismatch("timer_period", out_data.timer_period, want.timer_period);
				end
			end
			if (in_valid && in_ready)
				pending_q.push_back(predict_result(in_data));
			outstanding <= pending_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the stepper positioner: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
	import sph_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam int LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FACTOR;
	logic [15:0]          cfg_data = '0;

	int outstanding;
	int failures;
	int results_checked;
	int zero_moves;
	int homes_done;
	int cycles = 0;
	int items_sent = 0;
	int setups = 0;
	bit calm = 1'b0;

	stepper_positioner_with_homing u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sph_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.outstanding     (outstanding),
		.failures        (failures),
		.results_checked (results_checked),
		.zero_moves      (zero_moves),
		.homes_done      (homes_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side stalls
	initial begin
		int on_len;
		int off_len;
		forever begin
			out_ready <= 1'b1;
			on_len = $urandom_range(1, 12);
			repeat (on_len) @(posedge clk);
			off_len = calm ? 0 : pick_gap();
			if (off_len > 0) begin
				out_ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [AMT_W-1:0] amt, logic lvl);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{command: cmd, move_amount: amt, switch_level: lvl};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_setup(logic [15:0] factor, logic [10:0] spm, logic [15:0] max_pos,
	                           logic [15:0] move_per, logic [15:0] home_per,
	                           logic [9:0] debounce);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [15:0]          val [6];
		idx = '{CFG_FACTOR, CFG_SPM, CFG_MAX, CFG_MOVE_PER, CFG_HOME_PER, CFG_DEBOUNCE};
		val = '{factor, 16'(spm), max_pos, move_per, home_per, 16'(debounce)};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		setups++;
	endtask

	function automatic logic signed [AMT_W-1:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return -16'sd1;
				default: return 16'sd1;
			endcase
		end else if (r < 75) begin
			return $urandom_range(0, 1) ? AMT_W'($urandom_range(1, 12))
			                            : -AMT_W'($urandom_range(1, 12));
		end
		return AMT_W'($urandom);
	endfunction

	task automatic random_item();
		int                      r;
		logic [CMD_W-1:0]        cmd;
		r = $urandom_range(0, 99);
		if (r < 38)
			cmd = CMD_STEP;
		else if (r < 58)
			cmd = CMD_MS_TICK;
		else if (r < 72)
			cmd = CMD_MOVE;
		else if (r < 82)
			cmd = CMD_EDGE;
		else if (r < 89)
			cmd = CMD_HOME;
		else if (r < 95)
			cmd = CMD_STOP;
		else if (r < 97)
			cmd = CMD_SPARE_A;
		else
			cmd = CMD_SPARE_B;
		send_item(cmd, pick_amount(), 1'($urandom_range(0, 1)));
	endtask

	task automatic random_setup();
		logic [15:0] factor;
		logic [10:0] spm;
		logic [15:0] max_pos;
		logic [9:0]  debounce;
		case ($urandom_range(0, 3))
			0: factor = 16'($urandom_range(1, 64));
			1: factor = 16'($urandom_range(64, 1024));
			2: factor = 16'($urandom);
			default: factor = RST_FACTOR;
		endcase
		spm = $urandom_range(0, 3) == 0 ? 11'($urandom_range(1, 1024))
		                                : 11'($urandom_range(1, 4));
		max_pos = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
		                                    : 16'($urandom_range(1, 40));
		debounce = $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1000))
		                                     : 10'($urandom_range(0, 4));
		write_setup(factor, spm, max_pos, 16'($urandom_range(1, 65535)),
		            16'($urandom_range(1, 65535)), debounce);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: spare codes, idle step, zero and clamped moves, extremes
		send_item(CMD_SPARE_A, 16'sd0, 1'b0);
		send_item(CMD_SPARE_B, -16'sd1, 1'b1);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		send_item(CMD_MOVE, 16'sd0, 1'b0);
		send_item(CMD_MOVE, -16'sd5, 1'b0);
		send_item(CMD_MOVE, 16'sd1, 1'b0);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		send_item(CMD_STOP, 16'sd0, 1'b0);
		send_item(CMD_MOVE, 16'sd32767, 1'b0);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		send_item(CMD_STOP, 16'sd0, 1'b0);
		finish_phase();

		// position now above the range end
		write_setup(RST_FACTOR, RST_SPM, 16'd1, RST_MOVE_PER, RST_HOME_PER, 10'd0);
		send_item(CMD_MOVE, 16'sd1, 1'b0);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		send_item(CMD_HOME, 16'sd0, 1'b0);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		send_item(CMD_EDGE, 16'sd0, 1'b0);
		send_item(CMD_MS_TICK, 16'sd0, 1'b0);
		send_item(CMD_EDGE, 16'sd0, 1'b0);
		send_item(CMD_HOME, 16'sd0, 1'b0);
		send_item(CMD_MS_TICK, 16'sd0, 1'b0);
		send_item(CMD_EDGE, 16'sd0, 1'b1);
		send_item(CMD_MOVE, -16'sd32768, 1'b0);
		finish_phase();

		// zero range end
		write_setup(RST_FACTOR, RST_SPM, 16'd0, RST_MOVE_PER, RST_HOME_PER, 10'd0);
		send_item(CMD_MOVE, 16'sd100, 1'b0);
		send_item(CMD_STEP, 16'sd0, 1'b0);
		finish_phase();

		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 4 == 3);
			case (ph)
				0: write_setup(16'd0, 11'd1, 16'd1, 16'd1, 16'd1, 10'd0);
				1: write_setup(16'hFFFF, 11'd1024, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1000);
				2: write_setup(RST_FACTOR, RST_SPM, RST_MAX, RST_MOVE_PER, RST_HOME_PER,
				               RST_DEBOUNCE);
				default: random_setup();
			endcase
			repeat (50) random_item();
			finish_phase();
		end

		$display("run covered %0d items under %0d setups, %0d results checked",
		         items_sent, setups, results_checked);
		$display("%0d moves clamped to no motion, %0d homing runs ended at the switch",
		         zero_moves, homes_done);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
